// ----- rtl/core/spd_pkg.sv -----
// shared constants for the sample peak detector
package spd_pkg;

  localparam int TIME_BITS = 40;
  localparam int CFG_BITS  = 16;

  // configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_INTERVAL  = 1'b1;

  // configuration reset values
  localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 16'd100;
  localparam logic [CFG_BITS-1:0] INTERVAL_RESET  = 16'd10;

endpackage

// ----- rtl/core/spd_fifo.sv -----
// two-entry queue between the detection front and the interpolation back
module spd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr_r <= ~wptr_r;
      end
      if (pop && !empty) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/core/spd_front.sv -----
// sample history, difference tracking and peak classification
module spd_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 32,
  parameter int ENTRY_BITS  = INDEX_BITS + 3 * SAMPLE_BITS + 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 end_of_stream,
  input  logic signed [spd_pkg::CFG_BITS-1:0]  threshold,
  output logic                                 push,
  output logic [ENTRY_BITS-1:0]                entry
);
  import spd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_BITS-1:0] older_r, older_nxt;
  logic signed [SAMPLE_BITS:0]   pdiff_r, pdiff_nxt;
  logic [INDEX_BITS-1:0]         cnt_r, cnt_nxt;

  logic signed [SAMPLE_BITS:0]   d1;
  logic signed [SAMPLE_BITS+1:0] den;
  logic signed [SAMPLE_BITS+1:0] dsum;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          is_peak;

  // differences and peak value side
  always_comb begin
    d1   = $signed({sample[SAMPLE_BITS-1], sample}) - $signed({prev_r[SAMPLE_BITS-1], prev_r});
    den  = $signed({pdiff_r[SAMPLE_BITS], pdiff_r}) - $signed({d1[SAMPLE_BITS], d1});
    dsum = $signed({pdiff_r[SAMPLE_BITS], pdiff_r}) + $signed({d1[SAMPLE_BITS], d1});
    if (dsum[SAMPLE_BITS+1]) begin
      value = (prev_r > older_r) ? prev_r : older_r;
    end else begin
      value = (sample > prev_r) ? sample : prev_r;
    end
    is_peak = (|cnt_r[INDEX_BITS-1:1]) && (pdiff_r > 0) && (d1 <= 0) && (value > threshold);
  end

  assign push  = accept && (is_peak || end_of_stream);
  assign entry = {end_of_stream, is_peak, cnt_r, pdiff_r, den, value};

  // history update, cleared at end of stream
  always_comb begin
    prev_nxt  = sample;
    older_nxt = prev_r;
    pdiff_nxt = d1;
    cnt_nxt   = cnt_r + INDEX_BITS'(1);
    if (end_of_stream) begin
      prev_nxt  = '0;
      older_nxt = '0;
      pdiff_nxt = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      older_r <= '0;
      pdiff_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      prev_r  <= prev_nxt;
      older_r <= older_nxt;
      pdiff_r <= pdiff_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/spd_back.sv -----
// quotient interpolation, peak merging and two-slot result buffer
module spd_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8,
  parameter int INDEX_BITS  = 32,
  parameter int ENTRY_BITS  = INDEX_BITS + 3 * SAMPLE_BITS + 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  logic [ENTRY_BITS-1:0]                q_entry,
  output logic                                 q_pop,
  input  logic [spd_pkg::CFG_BITS-1:0]         interval,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [spd_pkg::TIME_BITS-1:0]        out_peak_time,
  output logic signed [SAMPLE_BITS-1:0]        out_peak_value,
  output logic                                 out_last_of_run
);
  import spd_pkg::*;

  localparam int DW = SAMPLE_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int SW = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  logic [1:0] state_r;

  // item fields held while in work
  logic                          eos_r, peak_r;
  logic [INDEX_BITS-1:0]         idx_r;
  logic signed [SAMPLE_BITS-1:0] val_r;
  logic [DW-1:0]                 rem_r, den_r;
  logic [QW-1:0]                 quo_r;
  logic [SW-1:0]                 step_r;

  // pending peak
  logic                          pv_r, pv_nxt;
  logic [TIME_BITS-1:0]          pt_r, pt_nxt;
  logic signed [SAMPLE_BITS-1:0] pval_r, pval_nxt;

  // result slots
  logic [TIME_BITS-1:0]          ot_r [2];
  logic signed [SAMPLE_BITS-1:0] ov_r [2];
  logic [1:0]                    ol_r;
  logic [1:0]                    ocnt_r;

  logic [TIME_BITS-1:0]          ot_nxt [2];
  logic signed [SAMPLE_BITS-1:0] ov_nxt [2];
  logic [1:0]                    ol_nxt;
  logic [1:0]                    n_res;

  logic [DW-1:0]        cur;
  logic                 ge;
  logic [TIME_BITS-1:0] t_new;
  logic [TIME_BITS-1:0] t_gap;

  assign out_empty       = (ocnt_r == 2'd0);
  assign out_peak_time   = ot_r[0];
  assign out_peak_value  = ov_r[0];
  assign out_last_of_run = ol_r[0];
  assign q_pop = (state_r == ST_IDLE) && !q_empty && (ocnt_r == 2'd0);

  // one restoring division step
  always_comb begin
    cur = (step_r == SW'(FRAC_BITS)) ? rem_r : {rem_r[DW-2:0], 1'b0};
    ge  = (cur >= den_r);
  end

  // interpolated time and merge decisions
  always_comb begin
    t_new = TIME_BITS'({{TIME_BITS{1'b0}}, idx_r, {FRAC_BITS{1'b0}}})
          + TIME_BITS'(quo_r) - (TIME_BITS'(1) << (FRAC_BITS - 1));
    t_gap = t_new - pt_r;
    pv_nxt   = pv_r;
    pt_nxt   = pt_r;
    pval_nxt = pval_r;
    n_res    = 2'd0;
    ot_nxt[0] = pt_r;
    ov_nxt[0] = pval_r;
    ot_nxt[1] = pt_r;
    ov_nxt[1] = pval_r;
    ol_nxt    = 2'b00;
    if (peak_r) begin
      if (pv_r) begin
        if (t_gap < TIME_BITS'({interval, {FRAC_BITS{1'b0}}})) begin
          if (pval_r < val_r) begin
            pt_nxt   = t_new;
            pval_nxt = val_r;
          end
        end else begin
          n_res    = 2'd1;
          pt_nxt   = t_new;
          pval_nxt = val_r;
        end
      end else begin
        pv_nxt   = 1'b1;
        pt_nxt   = t_new;
        pval_nxt = val_r;
      end
    end
    if (eos_r) begin
      if (pv_nxt) begin
        ot_nxt[n_res[0]] = pt_nxt;
        ov_nxt[n_res[0]] = pval_nxt;
        n_res = n_res + 2'd1;
      end
      pv_nxt   = 1'b0;
      pt_nxt   = '0;
      pval_nxt = '0;
    end
    if (n_res == 2'd1) begin
      ol_nxt = 2'b01;
    end else if (n_res == 2'd2) begin
      ol_nxt = 2'b10;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pv_r    <= 1'b0;
      pt_r    <= '0;
      pval_r  <= '0;
      ocnt_r  <= 2'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            state_r <= q_entry[ENTRY_BITS-2] ? ST_DIV : ST_RES;
          end
        end
        ST_DIV: begin
          if (step_r == '0) begin
            state_r <= ST_RES;
          end
        end
        ST_RES: begin
          state_r <= ST_IDLE;
          pv_r    <= pv_nxt;
          pt_r    <= pt_nxt;
          pval_r  <= pval_nxt;
          ocnt_r  <= n_res;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (out_pop && !out_empty) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      eos_r  <= q_entry[ENTRY_BITS-1];
      peak_r <= q_entry[ENTRY_BITS-2];
      idx_r  <= q_entry[ENTRY_BITS-3 -: INDEX_BITS];
      rem_r  <= DW'(q_entry[SAMPLE_BITS+DW +: SAMPLE_BITS+1]);
      den_r  <= q_entry[SAMPLE_BITS +: DW];
      val_r  <= q_entry[SAMPLE_BITS-1:0];
      quo_r  <= '0;
      step_r <= SW'(FRAC_BITS);
    end else if (state_r == ST_DIV) begin
      rem_r  <= ge ? (cur - den_r) : cur;
      quo_r  <= {quo_r[QW-2:0], ge};
      step_r <= step_r - SW'(1);
    end
    if (state_r == ST_RES) begin
      ot_r[0] <= ot_nxt[0];
      ov_r[0] <= ov_nxt[0];
      ot_r[1] <= ot_nxt[1];
      ov_r[1] <= ov_nxt[1];
      ol_r    <= ol_nxt;
    end else if (out_pop && !out_empty) begin
      ot_r[0] <= ot_r[1];
      ov_r[0] <= ov_r[1];
      ol_r[0] <= ol_r[1];
    end
  end

endmodule

// ----- rtl/core/sample_peak_detector.sv -----
// top level of the sample peak detector
// Finite-difference peak detector for a stream of signed samples. Samples
// enter through a queue-like port and are classified combinationally when
// accepted; a found peak or an end-of-stream marker goes into a two-entry
// queue. The back end takes one queued item at a time: a peak item runs a
// restoring divider for the interpolation quotient, one quotient bit per
// cycle, and a new item is taken only once the last one's results are all
// popped. Samples without a peak are not queued but wait while the queue
// is full. Up to two results per item; last_of_run marks the final one.
// Write the registers only while the block is idle.
module sample_peak_detector #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8,
  parameter int INDEX_BITS  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 in_end_of_stream,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [spd_pkg::TIME_BITS-1:0]        out_peak_time,
  output logic signed [SAMPLE_BITS-1:0]        out_peak_value,
  output logic                                 out_last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [spd_pkg::CFG_BITS-1:0]         cfg_data
);
  import spd_pkg::*;

  localparam int ENTRY_BITS = INDEX_BITS + 3 * SAMPLE_BITS + 5;

  logic signed [CFG_BITS-1:0] thr_r;
  logic [CFG_BITS-1:0]        int_r;
  logic                       accept;
  logic                       q_push, q_pop, q_empty;
  logic [ENTRY_BITS-1:0]      q_wdata, q_rdata;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      int_r <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_data;
        CFG_INTERVAL:  int_r <= cfg_data;
        default:       thr_r <= thr_r;
      endcase
    end
  end

  spd_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .sample       (in_sample),
    .end_of_stream(in_end_of_stream),
    .threshold    (thr_r),
    .push         (q_push),
    .entry        (q_wdata)
  );

  spd_fifo #(
    .WIDTH(ENTRY_BITS)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (in_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  spd_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (q_rdata),
    .q_pop          (q_pop),
    .interval       (int_r),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_peak_time  (out_peak_time),
    .out_peak_value (out_peak_value),
    .out_last_of_run(out_last_of_run)
  );

endmodule

// ----- test/tb_top.sv -----
// testbench for the sample peak detector: queue driver, result monitor, peak predictor
`timescale 1ns / 1ps
module tb_top;
  import spd_pkg::*;

  localparam int SB = 16;
  localparam int FB = 8;
  localparam int TB = TIME_BITS;

  localparam int DIRECTED [18] = '{0, 200, 500, 500, 300, 600, 100, 32767, -32768, 32767,
                                   32767, -32768, 150, 400, 399, 120, 500, 0};

  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic                 eos;
  } sample_item_t;

  typedef struct packed {
    logic [TB-1:0]        ptime;
    logic signed [SB-1:0] pvalue;
    logic                 last;
  } peak_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [SB-1:0] in_sample = '0;
  logic in_end_of_stream = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [TB-1:0] out_peak_time;
  logic signed [SB-1:0] out_peak_value;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_THRESHOLD;
  logic [CFG_BITS-1:0] cfg_data = '0;

  sample_peak_detector u_dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic signed [15:0] thr_q;
  logic [15:0]        ival_q;
  logic signed [15:0] prev_s, old_s;
  logic signed [16:0] prev_d;
  logic [31:0]        count_q;
  logic               pend_v;
  logic [TB-1:0]      pend_t;
  logic signed [15:0] pend_val;

  sample_item_t pending_samples[$];
  peak_t        expected_peaks[$];
  int errors = 0;
  int n_items = 0;
  int n_peaks = 0;
  int send_idle = 22;
  int recv_idle = 82;

  task automatic report(input string what, input peak_t got, input peak_t exp_p);
    errors++;
    $display("mismatch %s: got t=%h v=%0d l=%b exp t=%h v=%0d l=%b", what,
             got.ptime, got.pvalue, got.last, exp_p.ptime, exp_p.pvalue, exp_p.last);
  endtask

  function automatic void clear_stream();
    prev_s = '0; old_s = '0; prev_d = '0; count_q = '0;
    pend_v = 1'b0; pend_t = '0; pend_val = '0;
  endfunction

  // predict the peaks released by one sample
  function automatic void predict_peaks(input sample_item_t it);
    logic signed [16:0] d1;
    logic signed [17:0] dsum;
    logic [63:0] den, q, t64;
    logic [TB-1:0] t, gap;
    logic signed [15:0] v;
    peak_t p;
    int n0;
    n0 = expected_peaks.size();
    d1 = 17'(it.sample) - 17'(prev_s);
    if (count_q >= 2 && prev_d > 0 && d1 <= 0) begin
      den = 64'(prev_d - d1);
      q = (64'(prev_d) << FB) / den;
      t64 = (64'(count_q) << FB) + q - (64'd1 << (FB - 1));
      t = t64[TB-1:0];
      dsum = 18'(prev_d) + 18'(d1);
      if (dsum < 0) v = (prev_s > old_s) ? prev_s : old_s;
      else v = (it.sample > prev_s) ? it.sample : prev_s;
      if (v > thr_q) begin
        if (pend_v) begin
          gap = t - pend_t;
          if (gap < ({24'd0, ival_q} << FB)) begin
            if (pend_val < v) begin
              pend_t = t; pend_val = v;
            end
          end else begin
            p.ptime = pend_t; p.pvalue = pend_val; p.last = 1'b0;
            expected_peaks.push_back(p);
            pend_t = t; pend_val = v;
          end
        end else begin
          pend_v = 1'b1; pend_t = t; pend_val = v;
        end
      end
    end
    old_s = prev_s;
    prev_s = it.sample;
    prev_d = d1;
    count_q = count_q + 1;
    if (it.eos) begin
      if (pend_v) begin
        p.ptime = pend_t; p.pvalue = pend_val; p.last = 1'b0;
        expected_peaks.push_back(p);
      end
      clear_stream();
    end
    if (expected_peaks.size() > n0)
      expected_peaks[expected_peaks.size()-1].last = 1'b1;
  endfunction

  // driver: one item per accepted push
  always @(posedge clk) begin
    if (in_push && !in_full) begin
      predict_peaks('{sample: in_sample, eos: in_end_of_stream});
      n_items++;
      void'(pending_samples.pop_front());
    end
    if (pending_samples.size() > 0) begin
      if (in_push && in_full) begin
        in_push <= 1'b1;
      end else if ($urandom_range(99) < send_idle) begin
        in_push <= 1'b0;
      end else begin
        in_push <= 1'b1;
        in_sample <= pending_samples[0].sample;
        in_end_of_stream <= pending_samples[0].eos;
      end
    end else begin
      in_push <= 1'b0;
    end
  end

  // monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    peak_t got, exp_p;
    if (rst_n && out_pop && !out_empty) begin
      got.ptime = out_peak_time; got.pvalue = out_peak_value; got.last = out_last_of_run;
      n_peaks++;
      if (expected_peaks.size() == 0) begin
        exp_p = '0;
        report("unexpected", got, exp_p);
      end else begin
        exp_p = expected_peaks.pop_front();
        if (got.ptime !== exp_p.ptime) report("peak_time", got, exp_p);
        if (got.pvalue !== exp_p.pvalue) report("peak_value", got, exp_p);
        if (got.last !== exp_p.last) report("last_of_run", got, exp_p);
      end
    end
    out_pop <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD) thr_q = data; else ival_q = data;
  endtask

  task automatic add_sample(input int s, input bit e);
    sample_item_t it;
    it.sample = s[15:0]; it.eos = e;
    pending_samples.push_back(it);
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_push || expected_peaks.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random samples: mostly noisy bumps, sometimes full-range noise or full-scale extremes, random end of stream
  task automatic random_block(input int count);
    int base, amp, s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: s = $urandom_range(65535) - 32768;
        1: s = ($urandom_range(1)) ? 32767 : -32768;
        default: begin
          base = int'(300.0 * $sin(i * 0.7));
          amp = $urandom_range(400);
          s = base + amp - 100;
        end
      endcase
      add_sample(s, $urandom_range(59) == 0);
    end
    add_sample(0, 1'b1);
  endtask

  initial begin
    thr_q = THRESHOLD_RESET; ival_q = INTERVAL_RESET;
    clear_stream();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: plateau, sharp peaks, extremes, close peaks merge, end of stream
    write_reg(CFG_THRESHOLD, 16'd100);
    write_reg(CFG_INTERVAL, 16'd3);
    foreach (DIRECTED[k])
      add_sample(DIRECTED[k], 1'b0);
    add_sample(700, 1'b0);
    add_sample(-5, 1'b1);
    add_sample(900, 1'b1);
    drain();
    // random phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 82; recv_idle = 22; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      case (ph)
        0: begin write_reg(CFG_THRESHOLD, 16'h8000); write_reg(CFG_INTERVAL, 16'd0); end
        1: begin write_reg(CFG_THRESHOLD, 16'h7fff); write_reg(CFG_INTERVAL, 16'hffff); end
        default: begin
          write_reg(CFG_THRESHOLD, 16'($urandom_range(400) - 100));
          write_reg(CFG_INTERVAL, 16'($urandom_range(20)));
        end
      endcase
      random_block(260);
      drain();
    end
    $display("covered %0d samples, %0d peaks checked across 7 register settings",
             n_items, n_peaks);
    if (errors == 0) $display("PASS sample_peak_detector");
    else $display("FAIL sample_peak_detector");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL sample_peak_detector");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/spd_pkg.sv
rtl/core/spd_fifo.sv
rtl/core/spd_front.sv
rtl/core/spd_back.sv
rtl/core/sample_peak_detector.sv
test/tb_top.sv
